// ===== hdl/sspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sspi_pkg
// Shared types and constants for the script sequence index parser: transaction
// payloads, parse phase codes and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sspi_pkg;

	// input transaction: one script byte
	typedef struct packed {
		logic       first_byte;
		logic [7:0] data_byte;
	} in_t;

	// output transaction: one parse report
	typedef struct packed {
		logic        entry_valid;
		logic [2:0]  entry_index;
		logic [15:0] entry_offset;
		logic        finished;
		logic        malformed;
		logic [2:0]  sequence_count;
	} out_t;

	// parse phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_TABLE = 2'd1;
	localparam logic [1:0] PH_CMDS  = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_TABLE_OFFSET = 2'd0;
	localparam logic [1:0] REG_TABLE_END    = 2'd1;
	localparam logic [1:0] REG_CMD_END      = 2'd2;

	// configuration reset values
	localparam logic [7:0] TABLE_OFFSET_RST = 8'd12;
	localparam logic [7:0] TABLE_END_RST    = 8'd85;
	localparam logic [7:0] CMD_END_RST      = 8'd254;

	// record layout
	localparam logic [16:0] ID_BYTE_OFS   = 17'd3;  // id byte of a time-table entry
	localparam logic [16:0] ENTRY_STEP    = 17'd4;  // time-table entry size
	localparam logic [16:0] CMD_ID_OFS    = 17'd2;  // command id within a record
	localparam logic [16:0] CMD_LEN_OFS   = 17'd3;  // command length within a record
	localparam logic [16:0] CMD_HDR_LEN   = 17'd4;  // header bytes in front of payload
	localparam logic [16:0] SEQ_END_LEN   = 17'd5;  // size of a sequence end record
	localparam logic [17:0] LIMIT_MARGIN  = 18'd2;  // records stop at length - 2

endpackage

// ===== hdl/script_sequence_index_parser.sv =====
// ----------------------------------------------------------------------------
// script_sequence_index_parser
// Streams a script image one byte per transaction and reports the start
// offset of each command sequence. A byte with first_byte set restarts the
// parse; bytes 0 and 1 give the script length. The time table is walked from
// table_offset in 4-byte entries until the table end id, then command records
// are walked and each sequence start is reported, up to MAX_SEQUENCES or the
// length limit. A missing table end gives a single malformed report. One byte
// is accepted every cycle: the parse state and the output register are updated
// in the same cycle, and intake pauses only while a report sits in the output
// register and out_ready is low. Bytes that give no report return nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module script_sequence_index_parser #(
	parameter int MAX_SEQUENCES = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sspi_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output sspi_pkg::out_t   out_data,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data
);

	import sspi_pkg::*;

	localparam logic [2:0] MAX_SEQ_C = 3'(MAX_SEQUENCES);

	// configuration registers
	logic [7:0]  table_offset_q;
	logic [7:0]  table_end_q;
	logic [7:0]  cmd_end_q;

	// parse state
	logic [1:0]  phase_q,  phase_n;
	logic [15:0] pos_q,    pos_n;
	logic [7:0]  low_q,    low_n;
	logic [15:0] len_q,    len_n;
	logic [16:0] rec_q,    rec_n;
	logic [2:0]  found_q,  found_n;

	// output register
	logic        out_valid_q;
	out_t        out_data_q;

	// next-state working values
	logic        in_fire;
	logic        res_valid;
	out_t        res;
	logic [15:0] pos_inc;
	logic [16:0] pos_ext;
	logic [16:0] rec_next;
	logic        rep_en;
	logic [16:0] rep_start;
	logic [2:0]  rep_count;
	logic        rep_fin;

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// configuration writes, indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_offset_q <= TABLE_OFFSET_RST;
			table_end_q    <= TABLE_END_RST;
			cmd_end_q      <= CMD_END_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TABLE_OFFSET: table_offset_q <= cfg_data;
				REG_TABLE_END:    table_end_q    <= cfg_data;
				REG_CMD_END:      cmd_end_q      <= cfg_data;
				default:          ;
			endcase
		end
	end

	// parse step for one byte
	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		low_n     = low_q;
		len_n     = len_q;
		rec_n     = rec_q;
		found_n   = found_q;
		res_valid = 1'b0;
		res       = '0;
		rep_en    = 1'b0;
		rep_start = '0;
		rep_count = '0;
		rep_fin   = 1'b0;
		rec_next  = '0;
		// saturating byte position
		pos_inc   = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : pos_q;
		pos_ext   = {1'b0, pos_inc};

		if (in_data.first_byte) begin
			phase_n = PH_TABLE;
			pos_n   = '0;
			low_n   = in_data.data_byte;
			len_n   = '0;
			rec_n   = {9'd0, table_offset_q} + ID_BYTE_OFS;
			found_n = '0;
		end else if (phase_q == PH_TABLE || phase_q == PH_CMDS) begin
			pos_n = pos_inc;
			if (phase_q == PH_TABLE) begin
				// time table walk
				if (pos_inc == 16'd1) begin
					len_n = {in_data.data_byte, low_q};
				end else if (pos_inc >= len_q) begin
					phase_n            = PH_DONE;
					res_valid          = 1'b1;
					res.finished       = 1'b1;
					res.malformed      = 1'b1;
				end else if (pos_ext == rec_q) begin
					if (in_data.data_byte == table_end_q) begin
						rep_en    = 1'b1;
						rep_start = pos_ext + 17'd1;
					end else begin
						rec_n = rec_q + ENTRY_STEP;
					end
				end
			end else begin
				// command record walk
				if (pos_ext == rec_q + CMD_ID_OFS) begin
					if (in_data.data_byte == cmd_end_q) begin
						rep_en    = 1'b1;
						rep_start = rec_q + SEQ_END_LEN;
					end
				end else if (pos_ext == rec_q + CMD_LEN_OFS) begin
					rec_next = rec_q + {9'd0, in_data.data_byte} + CMD_HDR_LEN;
					rec_n    = rec_next;
					if ({1'b0, rec_next} + LIMIT_MARGIN >= {2'b00, len_q}) begin
						phase_n            = PH_DONE;
						res_valid          = 1'b1;
						res.finished       = 1'b1;
						res.sequence_count = found_q;
					end
				end
			end
		end

		// sequence start report
		if (rep_en) begin
			rep_count = found_q + 3'd1;
			rep_fin   = (rep_count >= MAX_SEQ_C) ||
			            ({1'b0, rep_start} + LIMIT_MARGIN >= {2'b00, len_q});
			found_n   = rep_count;
			rec_n     = rep_start;
			phase_n   = rep_fin ? PH_DONE : PH_CMDS;
			res_valid          = 1'b1;
			res.entry_valid    = 1'b1;
			res.entry_index    = found_q;
			res.entry_offset   = rep_start[16] ? 16'hFFFF : rep_start[15:0];
			res.finished       = rep_fin;
			res.sequence_count = rep_count;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			low_q   <= '0;
			len_q   <= '0;
			rec_q   <= '0;
			found_q <= '0;
		end else if (in_fire) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			low_q   <= low_n;
			len_q   <= len_n;
			rec_q   <= rec_n;
			found_q <= found_n;
		end
	end

	// output transaction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			out_data_q <= res;
		end
	end

endmodule
